@@ rtl/cmm_pkg.sv @@
// Shared types, codes and constants of the complex matrix multiplier.
package cmm_pkg;

    localparam int MAX_DIM_DEF     = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACC_W           = 36;
    localparam int IDX_W           = 3;
    localparam int DIM_W           = 4;
    localparam int FUNC_W          = 2;
    localparam int CFG_ADDR_W      = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RSVD   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WAIT,
        ST_EMIT
    } cmm_state_t;

    typedef struct packed {
        logic             b_we;
        logic [IDX_W-1:0] b_row;
        logic [IDX_W-1:0] b_col;
        logic             rd_en;
        logic [IDX_W-1:0] rd_k;
        logic             mul_en;
        logic             acc_en;
        logic             acc_first;
        logic             shift;
    } cell_ctrl_t;

    // Clamp a dimension register: zero acts as one, above the maximum saturates.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                                 input logic [DIM_W-1:0] maxd);
        logic [DIM_W-1:0] d;
        d = r;
        if (r == '0)
            d = DIM_W'(1);
        else if (r > maxd)
            d = maxd;
        return d;
    endfunction

endpackage

@@ rtl/cmm_cell.sv @@
// One column cell: holds a column of B, a complex MAC and one product entry.
module cmm_cell import cmm_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CELL_IDX    = 0
) (
    input  logic                          aclk,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] a_re,
    input  logic signed [SAMPLE_BITS-1:0] a_im,
    input  logic [2*SAMPLE_BITS-1:0]      b_wdata,   // {im, re}
    input  logic signed [ACC_W-1:0]       shift_re,
    input  logic signed [ACC_W-1:0]       shift_im,
    output logic signed [ACC_W-1:0]       acc_re,
    output logic signed [ACC_W-1:0]       acc_im
);

    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PW = 2 * SAMPLE_BITS;

    logic [PW-1:0] b_mem [MAX_DIM];
    logic [PW-1:0] b_rd_reg;

    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [ACC_W-1:0] e_rr, e_ii, e_ri, e_ir;
    logic signed [ACC_W-1:0] sum_re, sum_im;
    logic signed [ACC_W-1:0] acc_re_reg, acc_im_reg;
    logic signed [SAMPLE_BITS-1:0] b_re, b_im;

    always_ff @(posedge aclk) begin
        if (ctrl.b_we && ctrl.b_col == IDX_W'(CELL_IDX))
            b_mem[ctrl.b_row[IW-1:0]] <= b_wdata;
        if (ctrl.rd_en)
            b_rd_reg <= b_mem[ctrl.rd_k[IW-1:0]];
    end

    assign b_re = $signed(b_rd_reg[SAMPLE_BITS-1:0]);
    assign b_im = $signed(b_rd_reg[PW-1:SAMPLE_BITS]);

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            p_rr_reg <= a_re * b_re;
            p_ii_reg <= a_im * b_im;
            p_ri_reg <= a_re * b_im;
            p_ir_reg <= a_im * b_re;
        end
    end

    // Fit products to the accumulator width: sign-extend or wrap.
    generate
        if (PW >= ACC_W) begin : g_wrap
            assign e_rr = $signed(p_rr_reg[ACC_W-1:0]);
            assign e_ii = $signed(p_ii_reg[ACC_W-1:0]);
            assign e_ri = $signed(p_ri_reg[ACC_W-1:0]);
            assign e_ir = $signed(p_ir_reg[ACC_W-1:0]);
        end else begin : g_ext
            assign e_rr = {{(ACC_W-PW){p_rr_reg[PW-1]}}, p_rr_reg};
            assign e_ii = {{(ACC_W-PW){p_ii_reg[PW-1]}}, p_ii_reg};
            assign e_ri = {{(ACC_W-PW){p_ri_reg[PW-1]}}, p_ri_reg};
            assign e_ir = {{(ACC_W-PW){p_ir_reg[PW-1]}}, p_ir_reg};
        end
    endgenerate

    assign sum_re = e_rr - e_ii;
    assign sum_im = e_ri + e_ir;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            acc_re_reg <= shift_re;
            acc_im_reg <= shift_im;
        end else if (ctrl.acc_en) begin
            acc_re_reg <= ctrl.acc_first ? sum_re : acc_re_reg + sum_re;
            acc_im_reg <= ctrl.acc_first ? sum_im : acc_im_reg + sum_im;
        end
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

@@ rtl/cmm_seq.sv @@
// Sequencer: configuration, store A, row/inner/column counters and pipeline control.
module cmm_seq import cmm_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [DIM_W-1:0]              cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [FUNC_W-1:0]             s_func,
    input  logic [IDX_W-1:0]              s_row,
    input  logic [IDX_W-1:0]              s_col,
    input  logic [2*SAMPLE_BITS-1:0]      s_val,     // {im, re}
    output cell_ctrl_t                    ctrl,
    output logic signed [SAMPLE_BITS-1:0] a_re,
    output logic signed [SAMPLE_BITS-1:0] a_im,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [IDX_W-1:0]              out_row,
    output logic [IDX_W-1:0]              out_col,
    output logic                          out_last
);

    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AD  = MAX_DIM * MAX_DIM;
    localparam int AW  = (AD > 1) ? $clog2(AD) : 1;
    localparam int PW  = 2 * SAMPLE_BITS;
    localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAX_DIM);

    cmm_state_t state_reg, state_next;
    logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [DIM_W-1:0] m_eff, n_eff, p_eff;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic v1_reg, v2_reg, f1_reg, f2_reg;
    logic issue, s_acc, m_acc, in_range, row_end, col_end, k_end;
    logic [PW-1:0] a_mem [AD];
    logic [PW-1:0] a_rd_reg;
    logic [AW-1:0] wr_addr, rd_addr;

    assign m_eff = eff_dim(rows_reg, MAXD);
    assign n_eff = eff_dim(inner_reg, MAXD);
    assign p_eff = eff_dim(cols_reg, MAXD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= DIM_W'(8);
            inner_reg <= DIM_W'(8);
            cols_reg  <= DIM_W'(8);
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ROWS_A:    rows_reg  <= cfg_wdata;
                CFG_INNER_LEN: inner_reg <= cfg_wdata;
                CFG_COLS_B:    cols_reg  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign in_range = (DIM_W'(s_row) < MAXD) && (DIM_W'(s_col) < MAXD);
    assign k_end    = (DIM_W'(k_reg) + DIM_W'(1)) == n_eff;
    assign col_end  = (DIM_W'(j_reg) + DIM_W'(1)) == p_eff;
    assign row_end  = (DIM_W'(i_reg) + DIM_W'(1)) == m_eff;

    // Next state and counters.
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_func == FUNC_MUL) begin
                    state_next = ST_CALC;
                    i_next     = '0;
                    k_next     = '0;
                end
            end
            ST_CALC: begin
                if (k_end) begin
                    state_next = ST_WAIT;
                    k_next     = '0;
                end else begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_WAIT: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = ST_EMIT;
                    j_next     = '0;
                end
            end
            ST_EMIT: begin
                if (m_acc) begin
                    if (col_end) begin
                        if (row_end) begin
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_CALC;
                            i_next     = i_reg + IW'(1);
                        end
                    end else begin
                        j_next = j_reg + IW'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        issue    = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_CALC: issue    = 1'b1;
            ST_WAIT: ;
            ST_EMIT: m_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            f1_reg    <= 1'b0;
            f2_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            f1_reg    <= issue && k_reg == '0;
            f2_reg    <= f1_reg;
        end
    end

    assign wr_addr = AW'(32'(s_row) * MAX_DIM + 32'(s_col));
    assign rd_addr = AW'(32'(i_reg) * MAX_DIM + 32'(k_reg));

    always_ff @(posedge aclk) begin
        if (s_acc && s_func == FUNC_LOAD_A && in_range)
            a_mem[wr_addr] <= s_val;
        if (issue)
            a_rd_reg <= a_mem[rd_addr];
    end

    assign a_re = $signed(a_rd_reg[SAMPLE_BITS-1:0]);
    assign a_im = $signed(a_rd_reg[PW-1:SAMPLE_BITS]);

    always_comb begin
        ctrl.b_we      = s_acc && s_func == FUNC_LOAD_B && in_range;
        ctrl.b_row     = s_row;
        ctrl.b_col     = s_col;
        ctrl.rd_en     = issue;
        ctrl.rd_k      = IDX_W'(k_reg);
        ctrl.mul_en    = v1_reg;
        ctrl.acc_en    = v2_reg;
        ctrl.acc_first = f2_reg;
        ctrl.shift     = m_acc;
    end

    assign out_row  = IDX_W'(i_reg);
    assign out_col  = IDX_W'(j_reg);
    assign out_last = row_end && col_end;

    a_calc_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> !m_tvalid && !s_tready)
        else $error("issue overlaps emit or accept");
    a_emit_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !v1_reg && !v2_reg)
        else $error("emit while MAC pipeline busy");
    a_mul_enters_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_func == FUNC_MUL |=> issue && k_reg == '0)
        else $error("compute beat did not start at k zero");

endmodule

@@ rtl/complex_matrix_multiply.sv @@
// Complex matrix multiplier top level: stream ports, sequencer and the chain of column cells.
//
// Load beats (func 0/1) write one Q1.15 complex entry of A or B; they stream back to back.
// A compute beat (func 2) blocks input until the whole product is out. For each row of
// the product, the inner loop runs one k per cycle through a shared read of store A,
// broadcast to MAX_DIM column cells that each hold one column of B and a complex MAC
// with its read/multiply/accumulate pipeline. The row then shifts out of the cell chain
// toward cell 0, one entry per accepted output beat.
// No clearing pass: entries read before they are loaded are undefined.
module complex_matrix_multiply import cmm_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [DIM_W-1:0]        cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // row_idx[2:0], col_idx[5:3], in_re, in_im, zero fill
    input  logic [((2*IDX_W+2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]       s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // out_row[2:0], out_col[5:3], out_re[41:6], out_im[77:42], zero fill
    output logic [((2*IDX_W+2*ACC_W+7)/8)*8-1:0] m_tdata,
    output logic                    m_tlast
);

    localparam int SW = 2 * IDX_W + 2 * SAMPLE_BITS;
    localparam int MW = ((2 * IDX_W + 2 * ACC_W + 7) / 8) * 8;
    localparam int MF = 2 * IDX_W + 2 * ACC_W;

    cell_ctrl_t ctrl;
    logic signed [SAMPLE_BITS-1:0] a_re, a_im;
    logic [IDX_W-1:0] out_row, out_col;
    logic out_last;
    logic signed [ACC_W-1:0] acc_re [MAX_DIM];
    logic signed [ACC_W-1:0] acc_im [MAX_DIM];
    logic [2*SAMPLE_BITS-1:0] s_val;

    assign s_val = s_tdata[SW-1:2*IDX_W];

    cmm_seq #(
        .MAX_DIM     (MAX_DIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_func    (s_tuser),
        .s_row     (s_tdata[IDX_W-1:0]),
        .s_col     (s_tdata[2*IDX_W-1:IDX_W]),
        .s_val     (s_val),
        .ctrl      (ctrl),
        .a_re      (a_re),
        .a_im      (a_im),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_last  (out_last)
    );

    generate
        for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
            logic signed [ACC_W-1:0] sh_re, sh_im;
            if (c == MAX_DIM - 1) begin : g_end
                assign sh_re = '0;
                assign sh_im = '0;
            end else begin : g_mid
                assign sh_re = acc_re[c+1];
                assign sh_im = acc_im[c+1];
            end
            cmm_cell #(
                .MAX_DIM     (MAX_DIM),
                .SAMPLE_BITS (SAMPLE_BITS),
                .CELL_IDX    (c)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .a_re     (a_re),
                .a_im     (a_im),
                .b_wdata  (s_val),
                .shift_re (sh_re),
                .shift_im (sh_im),
                .acc_re   (acc_re[c]),
                .acc_im   (acc_im[c])
            );
        end
    endgenerate

    assign m_tdata = {(MW - MF)'(0), acc_im[0], acc_re[0], out_col, out_row};
    assign m_tlast = out_last;

    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while product beat pending");
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("block not idle after last beat");
    a_mul_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == FUNC_MUL |=> !s_tready)
        else $error("input not blocked after compute beat");

endmodule

@@ bench/tb_top.sv @@
// Testbench for the complex matrix multiplier: directed and random loads and products.
`timescale 1ns / 100ps

module tb_top;
    import cmm_pkg::*;

    localparam int DIM  = MAX_DIM_DEF;
    localparam int SW   = SAMPLE_BITS_DEF;
    localparam int SD_W = ((2*IDX_W+2*SW+7)/8)*8;
    localparam int MD_W = ((2*IDX_W+2*ACC_W+7)/8)*8;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [ACC_W-1:0] re;
        logic [ACC_W-1:0] im;
        logic             last;
    } entry_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [DIM_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SD_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MD_W-1:0] m_tdata;
    logic m_tlast;

    complex_matrix_multiply dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow state of the block
    logic signed [SW-1:0] a_re [DIM*DIM], a_im [DIM*DIM];
    logic signed [SW-1:0] b_re [DIM*DIM], b_im [DIM*DIM];
    bit a_set [DIM*DIM], b_set [DIM*DIM];
    logic [DIM_W-1:0] reg_rows = DIM_W'(8), reg_inner = DIM_W'(8), reg_cols = DIM_W'(8);
    entry_t product_q [$];
    int errors = 0;
    int stall_hold = 0;
    bit no_idle = 0;

    function automatic int clamp_dim(logic [DIM_W-1:0] r);
        if (r == 0) return 1;
        if (r > DIM) return DIM;
        return int'(r);
    endfunction

    function automatic bit all_set();
        int m, n, p;
        m = clamp_dim(reg_rows); n = clamp_dim(reg_inner); p = clamp_dim(reg_cols);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++) if (!a_set[i*DIM+k]) return 0;
        for (int k = 0; k < n; k++)
            for (int j = 0; j < p; j++) if (!b_set[k*DIM+j]) return 0;
        return 1;
    endfunction

    task automatic predict_product();
        int m, n, p;
        longint acc_re, acc_im;
        entry_t e;
        m = clamp_dim(reg_rows); n = clamp_dim(reg_inner); p = clamp_dim(reg_cols);
        for (int i = 0; i < m; i++)
            for (int j = 0; j < p; j++) begin
                acc_re = 0; acc_im = 0;
                for (int k = 0; k < n; k++) begin
                    acc_re += longint'(a_re[i*DIM+k]) * b_re[k*DIM+j]
                            - longint'(a_im[i*DIM+k]) * b_im[k*DIM+j];
                    acc_im += longint'(a_re[i*DIM+k]) * b_im[k*DIM+j]
                            + longint'(a_im[i*DIM+k]) * b_re[k*DIM+j];
                end
                e.row = IDX_W'(i); e.col = IDX_W'(j);
                e.re = acc_re[ACC_W-1:0]; e.im = acc_im[ACC_W-1:0];
                e.last = (i == m-1) && (j == p-1);
                product_q.push_back(e);
            end
    endtask

    task automatic send_beat(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                             logic [SW-1:0] re, logic [SW-1:0] im);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        // drop valid only while idling, so back-to-back beats keep it high
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= SD_W'({im, re, c, r});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (fn == FUNC_LOAD_A) begin
            a_re[r*DIM+c] = re; a_im[r*DIM+c] = im; a_set[r*DIM+c] = 1;
        end else if (fn == FUNC_LOAD_B) begin
            b_re[r*DIM+c] = re; b_im[r*DIM+c] = im; b_set[r*DIM+c] = 1;
        end else if (fn == FUNC_MUL) begin
            predict_product();
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (product_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [DIM_W-1:0] val);
        cfg_we <= 1'b1; cfg_addr <= addr; cfg_wdata <= val;
        @(posedge aclk);
        if (addr == CFG_ROWS_A) reg_rows = val;
        else if (addr == CFG_INNER_LEN) reg_inner = val;
        else reg_cols = val;
    endtask

    task automatic set_dims(logic [DIM_W-1:0] m, logic [DIM_W-1:0] n, logic [DIM_W-1:0] p);
        drain();
        write_reg(CFG_ROWS_A, m);
        write_reg(CFG_INNER_LEN, n);
        write_reg(CFG_COLS_B, p);
        cfg_we <= 1'b0;
    endtask

    // Load every entry of A and B that the current dimensions use
    task automatic fill_operands(int mode);
        logic [SW-1:0] re, im;
        int m, n, p;
        m = clamp_dim(reg_rows); n = clamp_dim(reg_inner); p = clamp_dim(reg_cols);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++) begin
                re = mode == 1 ? 16'h8000 : mode == 2 ? 16'h7fff : 16'($urandom);
                im = mode == 1 ? 16'h8000 : mode == 2 ? 16'h8000 : 16'($urandom);
                send_beat(FUNC_LOAD_A, IDX_W'(i), IDX_W'(k), re, im);
            end
        for (int k = 0; k < n; k++)
            for (int j = 0; j < p; j++) begin
                re = mode == 1 ? 16'h8000 : mode == 2 ? 16'h7fff : 16'($urandom);
                im = mode == 1 ? 16'h8000 : mode == 2 ? 16'h7fff : 16'($urandom);
                send_beat(FUNC_LOAD_B, IDX_W'(k), IDX_W'(j), re, im);
            end
    endtask

    task automatic test_directed();
        set_dims(1, 1, 1);
        send_beat(FUNC_LOAD_A, 0, 0, 16'h8000, 16'h8000);
        send_beat(FUNC_LOAD_B, 0, 0, 16'h8000, 16'h7fff);
        send_beat(FUNC_MUL, 0, 0, 0, 0);
        // unused function code and out-of-dimension loads
        send_beat(FUNC_RSVD, 0, 0, 16'h1234, 16'h5678);
        send_beat(FUNC_LOAD_A, 7, 7, 16'h7fff, 16'h8000);
        send_beat(FUNC_LOAD_B, 7, 7, 16'hffff, 16'h0001);
        send_beat(FUNC_MUL, 7, 7, 16'hffff, 16'hffff);
        // zero dimensions act as one
        set_dims(0, 0, 0);
        send_beat(FUNC_MUL, 0, 0, 0, 0);
    endtask

    task automatic test_extremes();
        set_dims(8, 8, 8);
        no_idle = 1;
        fill_operands(1);
        send_beat(FUNC_MUL, 0, 0, 0, 0);
        fill_operands(2);
        no_idle = 0;
        send_beat(FUNC_MUL, 0, 0, 0, 0);
        // above the maximum saturates
        set_dims(15, 15, 15);
        send_beat(FUNC_MUL, 0, 0, 0, 0);
    endtask

    task automatic test_backpressure();
        set_dims(2, 3, 4);
        fill_operands(0);
        stall_hold = 150;
        send_beat(FUNC_MUL, 0, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            send_beat(FUNC_LOAD_A, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                      16'($urandom), 16'($urandom));
        send_beat(FUNC_MUL, 0, 0, 0, 0);
    endtask

    task automatic test_random();
        int sent;
        logic [FUNC_W-1:0] fn;
        sent = 0;
        while (sent < 80) begin
            if ($urandom_range(0, 3) == 0)
                set_dims(DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(1, 4)),
                         DIM_W'($urandom_range(1, 8)));
            else if ($urandom_range(0, 2) == 0)
                set_dims(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)),
                         DIM_W'($urandom_range(1, 3)));
            fill_operands(0);
            sent += clamp_dim(reg_rows)*clamp_dim(reg_inner)
                  + clamp_dim(reg_inner)*clamp_dim(reg_cols);
            // noise: random loads, unused code, then a product if safe
            repeat ($urandom_range(0, 4)) begin
                fn = FUNC_W'($urandom_range(0, 3));
                if (fn == FUNC_MUL) fn = FUNC_RSVD;
                send_beat(fn, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                          16'($urandom), 16'($urandom));
                sent++;
            end
            if (all_set()) begin
                send_beat(FUNC_MUL, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                          16'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    // Receiver: random ready, with an occasional long hold-off
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (stall_hold > 0) begin
                m_tready <= 1'b0;
                repeat (stall_hold) @(posedge aclk);
                stall_hold = 0;
            end
            gap = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        entry_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.row = m_tdata[2:0];
            got.col = m_tdata[5:3];
            got.re  = m_tdata[41:6];
            got.im  = m_tdata[77:42];
            got.last = m_tlast;
            if (product_q.size() == 0) begin
                $display("%0t: unexpected beat row %0d col %0d", $realtime, got.row, got.col);
                errors++;
            end else begin
                want = product_q.pop_front();
                if (got.row != want.row) begin
                    $display("%0t: row exp %0d got %0d", $realtime, want.row, got.row);
                    errors++;
                end
                if (got.col != want.col) begin
                    $display("%0t: col exp %0d got %0d", $realtime, want.col, got.col);
                    errors++;
                end
                if (got.re != want.re) begin
                    $display("%0t: re exp %h got %h", $realtime, want.re, got.re);
                    errors++;
                end
                if (got.im != want.im) begin
                    $display("%0t: im exp %h got %h", $realtime, want.im, got.im);
                    errors++;
                end
                if (got.last != want.last) begin
                    $display("%0t: last exp %0d got %0d", $realtime, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extremes();
        test_backpressure();
        test_random();
        drain();
        if (errors == 0 && product_q.size() == 0)
            $display("complex_matrix_multiply regression: pass");
        else
            $display("complex_matrix_multiply regression: fail");
        $finish;
    end

    initial begin
        #30ms;
        $display("complex_matrix_multiply regression: fail");
        $finish;
    end
endmodule
